// File: rtl/sorted_reminder_table_insert_defines.svh
// Assertion macros shared by the sorted reminder table RTL.
`ifndef SORTED_REMINDER_TABLE_INSERT_DEFINES_SVH
`define SORTED_REMINDER_TABLE_INSERT_DEFINES_SVH
`ifndef SYNTHESIS
`define SRTI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srti same-cycle check failed");
`define SRTI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srti next-cycle check failed");
`else
`define SRTI_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SRTI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/srti_pkg.sv
// Types and constants of the sorted reminder table.
package srti_pkg;

   localparam int MONTH_MIN = 1;
   localparam int MONTH_MAX = 12;
   localparam int DAY_MIN   = 1;
   localparam int DAY_MAX   = 31;
   localparam int HOUR_MAX  = 23;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FULL  = 3'd1,
      ST_MONTH = 3'd2,
      ST_DAY   = 3'd3,
      ST_HOUR  = 3'd4,
      ST_INDEX = 3'd5
   } status_type;

   // field order gives the (month, day, hour) ordering directly
   typedef struct packed {
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
   } key_type;

   typedef struct packed {
      key_type     key;
      logic [31:0] tag;
   } entry_type;

   typedef struct packed {
      status_type status;
      logic       later;
   } chk_type;

endpackage

// File: rtl/srti_if.sv
// Valid/ready channel interfaces for request and response beats.
interface srti_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [6:0]  month;
   logic [6:0]  day;
   logic [6:0]  hour;
   logic [31:0] tag;
   logic [5:0]  index;

   modport source (output valid, op, month, day, hour, tag, index, input ready);
   modport sink (input valid, op, month, day, hour, tag, index, output ready);
endinterface

interface srti_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  position;
   logic [3:0]  entry_month;
   logic [4:0]  entry_day;
   logic [4:0]  entry_hour;
   logic [31:0] entry_tag;
   logic [6:0]  count;

   modport source (output valid, status, position, entry_month, entry_day, entry_hour,
                   entry_tag, count, input ready);
   modport sink (input valid, status, position, entry_month, entry_day, entry_hour,
                 entry_tag, count, output ready);
endinterface

// File: rtl/srti_mem.sv
// Entry store: one write port, one registered read port.
module srti_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  srti_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output srti_pkg::entry_type rd_data
);

   srti_pkg::entry_type mem_ff [DEPTH];
   srti_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/srti_cmp.sv
// Field range check for new entries and the shared key comparator of the scan.
module srti_cmp (
   input  logic              full,
   input  logic [6:0]        month,
   input  logic [6:0]        day,
   input  logic [6:0]        hour,
   input  srti_pkg::key_type stored_key,
   input  srti_pkg::key_type new_key,
   output srti_pkg::chk_type chk
);

   logic [$bits(srti_pkg::key_type)-1:0] stored_bits;
   logic [$bits(srti_pkg::key_type)-1:0] new_bits;

   assign stored_bits = stored_key;
   assign new_bits    = new_key;

   always_comb begin
      chk.later = (stored_bits > new_bits);
      priority if (full) begin
         chk.status = srti_pkg::ST_FULL;
      end else if (month < 7'(srti_pkg::MONTH_MIN) || month > 7'(srti_pkg::MONTH_MAX)) begin
         chk.status = srti_pkg::ST_MONTH;
      end else if (day < 7'(srti_pkg::DAY_MIN) || day > 7'(srti_pkg::DAY_MAX)) begin
         chk.status = srti_pkg::ST_DAY;
      end else if (hour > 7'(srti_pkg::HOUR_MAX)) begin
         chk.status = srti_pkg::ST_HOUR;
      end else begin
         chk.status = srti_pkg::ST_OK;
      end
   end

endmodule

// File: rtl/sorted_reminder_table_insert.sv
// Sorted reminder table: inserts walk down from the top entry, one entry per cycle.
// Insert: the scan steps down with one compare and one memory read/write per cycle
// until the new entry's place is found; failed checks and empty table answer from idle.
// Read: registered memory read, then the response; a bad index answers from idle.
// One beat in flight: input ready returns once the response register can take a beat.
// Synchronous reset empties the table (count to 0); entry memory is not cleared.
`include "sorted_reminder_table_insert_defines.svh"
module sorted_reminder_table_insert #(
   parameter int CAPACITY = 64
) (
   input logic      clock,
   input logic      reset,
   srti_req_if.sink   req,
   srti_rsp_if.source rsp
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_PLACE  = 4'b0100,
      S_RDWAIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] j_ff, j_in;
   logic [5:0]    idx_ff, idx_in;
   srti_pkg::entry_type new_ff, new_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   srti_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [5:0]             rsp_pos_ff, rsp_pos_in;
   srti_pkg::entry_type    rsp_entry_ff, rsp_entry_in;
   logic [CW-1:0]          rsp_cnt_ff, rsp_cnt_in;

   logic                load;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   srti_pkg::entry_type wr_data;
   logic [AW-1:0]       rd_addr;
   srti_pkg::entry_type rd_data;
   srti_pkg::entry_type req_entry;
   srti_pkg::chk_type   chk;
   logic                full;
   logic                req_acc;

   assign full    = (cnt_ff == CW'(CAPACITY));
   assign req_acc = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);

   assign req_entry.key.month = req.month[3:0];
   assign req_entry.key.day   = req.day[4:0];
   assign req_entry.key.hour  = req.hour[4:0];
   assign req_entry.tag       = req.tag;

   srti_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   srti_cmp u_cmp (
      .full       (full),
      .month      (req.month),
      .day        (req.day),
      .hour       (req.hour),
      .stored_key (rd_data.key),
      .new_key    (new_ff.key),
      .chk        (chk)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      j_in          = j_ff;
      idx_in        = idx_ff;
      new_in        = new_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(j_ff + 1'b1);
      wr_data       = new_ff;
      rd_addr       = AW'(j_ff - 1'b1);
      load          = 1'b0;
      rsp_status_in = srti_pkg::ST_OK;
      rsp_pos_in    = '0;
      rsp_entry_in  = '0;
      rsp_cnt_in    = cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = AW'(cnt_ff - 1'b1);
            if (req_acc) begin
               new_in = req_entry;
               idx_in = req.index;
               if (!req.op) begin
                  if (chk.status != srti_pkg::ST_OK) begin
                     load          = 1'b1;
                     rsp_status_in = chk.status;
                  end else if (cnt_ff == '0) begin
                     wr_en      = 1'b1;
                     wr_addr    = '0;
                     wr_data    = req_entry;
                     cnt_in     = CW'(1);
                     load       = 1'b1;
                     rsp_cnt_in = CW'(1);
                  end else begin
                     j_in     = AW'(cnt_ff - 1'b1);
                     state_in = S_SCAN;
                  end
               end else begin
                  rd_addr = AW'(req.index);
                  if (32'(req.index) >= 32'(cnt_ff)) begin
                     load          = 1'b1;
                     rsp_status_in = srti_pkg::ST_INDEX;
                     rsp_pos_in    = req.index;
                  end else begin
                     state_in = S_RDWAIT;
                  end
               end
            end
         end
         S_SCAN: begin
            wr_en = 1'b1;
            if (chk.later) begin
               // stored entry sorts after the new one: move it up a place
               wr_data = rd_data;
               if (j_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  j_in = AW'(j_ff - 1'b1);
               end
            end else begin
               cnt_in     = CW'(cnt_ff + 1'b1);
               load       = 1'b1;
               rsp_pos_in = 6'(AW'(j_ff + 1'b1));
               rsp_cnt_in = CW'(cnt_ff + 1'b1);
               state_in   = S_IDLE;
            end
         end
         S_PLACE: begin
            wr_en      = 1'b1;
            wr_addr    = '0;
            cnt_in     = CW'(cnt_ff + 1'b1);
            load       = 1'b1;
            rsp_cnt_in = CW'(cnt_ff + 1'b1);
            state_in   = S_IDLE;
         end
         S_RDWAIT: begin
            load         = 1'b1;
            rsp_pos_in   = idx_ff;
            rsp_entry_in = rd_data;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff   <= j_in;
      idx_ff <= idx_in;
      new_ff <= new_in;
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_cnt_ff    <= rsp_cnt_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.position    = rsp_pos_ff;
   assign rsp.entry_month = rsp_entry_ff.key.month;
   assign rsp.entry_day   = rsp_entry_ff.key.day;
   assign rsp.entry_hour  = rsp_entry_ff.key.hour;
   assign rsp.entry_tag   = rsp_entry_ff.tag;
   assign rsp.count       = 7'(rsp_cnt_ff);

   `SRTI_ASSERT_SAME(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(CAPACITY))
   `SRTI_ASSERT_SAME(a_scan_in_range, clock, reset, state_ff == S_SCAN, CW'(j_ff) < cnt_ff)
   `SRTI_ASSERT_SAME(a_no_overwrite, clock, reset, load, !rsp_valid_ff || rsp.ready)
   `SRTI_ASSERT_NEXT(a_full_reject, clock, reset, req_acc && !req.op && full, (rsp_valid_ff && (rsp_status_ff == srti_pkg::ST_FULL)))

endmodule

// File: tb/srti_tb_pkg.sv
// Opcodes shared by the sorted reminder table testbench files.
package srti_tb_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

endpackage

// File: tb/srti_table_checker.sv
// Checker for the sorted reminder table: predicts every response beat and compares it.
module srti_table_checker #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   srti_req_if         req,
   srti_rsp_if         rsp,
   output int unsigned errors,
   output int unsigned pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      srti_pkg::status_type status;
      logic [5:0]           position;
      logic [3:0]           month;
      logic [4:0]           day;
      logic [4:0]           hour;
      logic [31:0]          tag;
      logic [6:0]           count;
   } table_rsp_type;

   srti_pkg::entry_type sorted_entries [CAPACITY];
   int unsigned         held;
   int unsigned         mismatches;
   table_rsp_type       expected_rsps [$];

   function automatic table_rsp_type predict_table_beat(input logic op,
                                                        input logic [6:0] month,
                                                        input logic [6:0] day,
                                                        input logic [6:0] hour,
                                                        input logic [31:0] tag,
                                                        input logic [5:0] index);
      table_rsp_type     res;
      srti_pkg::key_type k;
      int unsigned       slot;
      res        = '0;
      res.status = srti_pkg::ST_OK;
      if (op == srti_tb_pkg::OP_INSERT) begin
         if (held >= CAPACITY) begin
            res.status = srti_pkg::ST_FULL;
         end else if (month < srti_pkg::MONTH_MIN || month > srti_pkg::MONTH_MAX) begin
            res.status = srti_pkg::ST_MONTH;
         end else if (day < srti_pkg::DAY_MIN || day > srti_pkg::DAY_MAX) begin
            res.status = srti_pkg::ST_DAY;
         end else if (hour > srti_pkg::HOUR_MAX) begin
            res.status = srti_pkg::ST_HOUR;
         end else begin
            k.month = month[3:0];
            k.day   = day[4:0];
            k.hour  = hour[4:0];
            // equal keys go after the ones already held
            slot = 0;
            while (slot < held && sorted_entries[slot].key <= k) slot++;
            for (int j = held; j > slot; j--) sorted_entries[j] = sorted_entries[j - 1];
            sorted_entries[slot].key = k;
            sorted_entries[slot].tag = tag;
            held++;
            res.position = slot[5:0];
         end
      end else begin
         res.position = index;
         if (index >= held || index >= CAPACITY) begin
            res.status = srti_pkg::ST_INDEX;
         end else begin
            res.month = sorted_entries[index].key.month;
            res.day   = sorted_entries[index].key.day;
            res.hour  = sorted_entries[index].key.hour;
            res.tag   = sorted_entries[index].tag;
         end
      end
      res.count = held[6:0];
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         if (mismatches < MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      table_rsp_type want;
      if (reset) begin
         held = 0;
         expected_rsps.delete();
      end else begin
         if (req.valid && req.ready)
            expected_rsps.push_back(predict_table_beat(req.op, req.month, req.day, req.hour,
                                                       req.tag, req.index));
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $error("response beat with nothing outstanding");
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", 32'(want.status), 32'(rsp.status));
               check_field("position", 32'(want.position), 32'(rsp.position));
               check_field("entry_month", 32'(want.month), 32'(rsp.entry_month));
               check_field("entry_day", 32'(want.day), 32'(rsp.entry_day));
               check_field("entry_hour", 32'(want.hour), 32'(rsp.entry_hour));
               check_field("entry_tag", want.tag, rsp.entry_tag);
               check_field("count", 32'(want.count), 32'(rsp.count));
            end
         end
      end
      pending <= expected_rsps.size();
      errors  <= mismatches;
   end

endmodule

// File: tb/tb.sv
// Top of the sorted reminder table testbench: clock, reset, stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY       = 64;
   localparam int CLK_PERIOD     = 10;
   localparam int RANDOM_BEATS   = 1250;
   localparam int HOLD_CYCLES    = 300;
   localparam int TIMEOUT_CYCLES = 1_000_000;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned inserts_sent;
   int unsigned reads_sent;
   bit          sender_calm;

   srti_req_if req_ch ();
   srti_rsp_if rsp_ch ();

   sorted_reminder_table_insert #(.CAPACITY(CAPACITY)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   srti_table_checker #(.CAPACITY(CAPACITY)) u_table_check (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .errors  (fail_count),
      .pending (pending_count)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("** sorted_reminder_table_insert: FAILED **");
      $finish;
   end

   // response side: random stalls, one long hold-off early, a calm stretch later
   initial begin
      int unsigned rsp_seen;
      int unsigned hold_left;
      bit          hold_done;
      rsp_seen  = 0;
      hold_left = 0;
      hold_done = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) rsp_seen++;
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && rsp_seen >= 40) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_seen >= 800 && rsp_seen < 1000) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= 31);
         end
      end
   end

   task automatic send_beat(input logic op, input logic [6:0] month, input logic [6:0] day,
                            input logic [6:0] hour, input logic [31:0] tag,
                            input logic [5:0] index);
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.month <= month;
      req_ch.day   <= day;
      req_ch.hour  <= hour;
      req_ch.tag   <= tag;
      req_ch.index <= index;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (op == srti_tb_pkg::OP_READ) reads_sent++;
      else inserts_sent++;
      if (!sender_calm && $urandom_range(0, 99) < 31) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 31);
      end
   endtask

   task automatic read_beat(input logic [5:0] index);
      send_beat(srti_tb_pkg::OP_READ, 7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)),
                7'($urandom_range(0, 99)), $urandom, index);
   endtask

   // stop offering and wait for every outstanding beat to come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic random_beat();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         read_beat(6'($urandom_range(0, 63)));
      end else if (pick < 52) begin
         // noise: any field may be out of range
         send_beat(srti_tb_pkg::OP_INSERT, 7'($urandom_range(0, 99)),
                   7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)), $urandom,
                   6'($urandom_range(0, 63)));
      end else if (pick < 65) begin
         // narrow key space so equal keys pile up
         send_beat(srti_tb_pkg::OP_INSERT, 7'($urandom_range(1, 2)),
                   7'($urandom_range(30, 31)), 7'($urandom_range(22, 23)), $urandom,
                   6'($urandom_range(0, 63)));
      end else begin
         send_beat(srti_tb_pkg::OP_INSERT, 7'($urandom_range(1, 12)),
                   7'($urandom_range(1, 31)), 7'($urandom_range(0, 23)), $urandom,
                   6'($urandom_range(0, 63)));
      end
   endtask

   initial begin
      inserts_sent = 0;
      reads_sent   = 0;
      sender_calm  = 0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op    <= srti_tb_pkg::OP_INSERT;
      req_ch.month <= '0;
      req_ch.day   <= '0;
      req_ch.hour  <= '0;
      req_ch.tag   <= '0;
      req_ch.index <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty read, check order of field errors, ordering with equal keys
      read_beat(6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd0, 7'd0, 7'd99, 32'h0000_0000, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd13, 7'd5, 7'd5, 32'h1234_5678, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd99, 7'd31, 7'd23, 32'hffff_ffff, 6'd63);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd1, 7'd0, 7'd0, 32'h0000_0001, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd12, 7'd32, 7'd0, 32'h8000_0000, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd12, 7'd99, 7'd99, 32'h5555_5555, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd6, 7'd15, 7'd24, 32'haaaa_aaaa, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd6, 7'd15, 7'd99, 32'h0f0f_0f0f, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd12, 7'd31, 7'd23, 32'hffff_ffff, 6'd63);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd1, 7'd1, 7'd0, 32'h0000_0000, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd6, 7'd15, 7'd12, 32'h0000_1111, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd6, 7'd15, 7'd12, 32'h0000_2222, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd1, 7'd1, 7'd0, 32'h0000_3333, 6'd0);
      send_beat(srti_tb_pkg::OP_INSERT, 7'd6, 7'd15, 7'd11, 32'h0000_4444, 6'd0);
      for (int i = 0; i <= 6; i++) read_beat(i[5:0]);
      read_beat(6'd63);
      wait_drained();

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         sender_calm = (i >= 800 && i < 1000);
         if (i == 600) wait_drained();
         random_beat();
      end
      sender_calm = 0;

      wait_drained();
      repeat (100) @(posedge clock);

      $display("run covered %0d insert and %0d read beats: field errors, table full, reads",
               inserts_sent, reads_sent);
      $display("past the end, with a %0d-cycle response hold-off and mid-run drains",
               HOLD_CYCLES);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** sorted_reminder_table_insert: PASSED **");
      end else begin
         $display("** sorted_reminder_table_insert: FAILED **");
      end
      $finish;
   end

endmodule
